// ===== design/sensor_scratchpad_validator_assert.svh =====
// assertion macros for the scratchpad validator checker
// used by ssv_checker; needs clk and rst_n in scope at the point of use
`ifndef SENSOR_SCRATCHPAD_VALIDATOR_ASSERT_SVH
`define SENSOR_SCRATCHPAD_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ssv_pkg.sv =====
// shared constants for the sensor scratchpad validator
// no dependencies
package ssv_pkg;

  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam int unsigned CRC_BYTES      = 8;
  localparam logic [15:0] POWER_ON_RESET = 16'd1360;

  localparam logic        OP_BYTE   = 1'b0;
  localparam logic        OP_ABSENT = 1'b1;

  localparam logic [2:0] FAIL_NONE     = 3'd0;
  localparam logic [2:0] FAIL_ABSENT   = 3'd1;
  localparam logic [2:0] FAIL_ZERO     = 3'd2;
  localparam logic [2:0] FAIL_CRC      = 3'd3;
  localparam logic [2:0] FAIL_LEFTOVER = 3'd4;

endpackage

// ===== design/ssv_crc8_byte.sv =====
// byte-wide update of the reflected crc-8 (poly 0x8c, lsb first)
// depends on ssv_pkg
module ssv_crc8_byte (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data_in;
    for (int i = 0; i < 8; i++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ ssv_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    crc_out = c;
  end

endmodule

// ===== design/sensor_scratchpad_validator.sv =====
// top level of the sensor scratchpad validator
// depends on ssv_pkg and ssv_crc8_byte
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/ready   | opcode, data_byte
//   out     | output    | out_valid/ready  | reading_ok, fail_reason, temperature
//   cfg     | input     | cfg_wr_en        | power_on_value
//
// one byte per cycle while in_ready is high; the crc byte update and checks
// sit between the state and the output register, so a result appears in the
// cycle after its transfer; in_ready is high whenever the output register is
// empty or being taken. rst_n is synchronous: clears readout state and last
// good temperature, sets the first-reading flag, loads power_on_value with 1360
module sensor_scratchpad_validator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reading_ok,
  output logic [2:0]         out_fail_reason,
  output logic signed [15:0] out_temperature,
  input  logic               cfg_wr_en,
  input  logic signed [15:0] cfg_wr_data
);

  logic [3:0]  pos_r,   pos_nxt;
  logic [7:0]  crc_r,   crc_nxt;
  logic        seen_r,  seen_nxt;
  logic [7:0]  lo_r,    lo_nxt;
  logic [7:0]  hi_r,    hi_nxt;
  logic        first_r, first_nxt;
  logic [15:0] good_r,  good_nxt;
  logic [15:0] pov_r;

  logic        ovalid_r, ovalid_nxt;
  logic        ok_r,     ok_nxt;
  logic [2:0]  reason_r, reason_nxt;
  logic [15:0] temp_r,   temp_nxt;

  logic        xfer;
  logic [7:0]  crc_upd;
  logic [15:0] value;

  assign in_ready = !ovalid_r || out_ready;
  assign xfer     = in_valid && in_ready;
  assign value    = {hi_r, lo_r};

  ssv_crc8_byte u_crc (
    .crc_in  (crc_r),
    .data_in (in_data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    logic       emit;
    logic [2:0] reason;
    logic       any_nz;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    seen_nxt  = seen_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    first_nxt = first_r;
    good_nxt  = good_r;
    emit      = 1'b0;
    reason    = ssv_pkg::FAIL_NONE;
    any_nz    = seen_r || (in_data_byte != 8'd0);

    if (xfer) begin
      if (in_opcode == ssv_pkg::OP_ABSENT) begin
        emit   = 1'b1;
        reason = ssv_pkg::FAIL_ABSENT;
      end else if (pos_r < 4'(ssv_pkg::CRC_BYTES)) begin
        crc_nxt  = crc_upd;
        seen_nxt = any_nz;
        if (pos_r == 4'd0) begin
          lo_nxt = in_data_byte;
        end else if (pos_r == 4'd1) begin
          hi_nxt = in_data_byte;
        end
        pos_nxt = pos_r + 4'd1;
      end else begin
        emit = 1'b1;
        if (!any_nz) begin
          reason = ssv_pkg::FAIL_ZERO;
        end else if (crc_r != in_data_byte) begin
          reason = ssv_pkg::FAIL_CRC;
        end else begin
          first_nxt = 1'b0;
          if (first_r && value == pov_r) begin
            reason = ssv_pkg::FAIL_LEFTOVER;
          end else begin
            good_nxt = value;
            reason   = ssv_pkg::FAIL_NONE;
          end
        end
      end
      if (emit) begin
        pos_nxt  = 4'd0;
        crc_nxt  = 8'd0;
        seen_nxt = 1'b0;
        lo_nxt   = 8'd0;
        hi_nxt   = 8'd0;
      end
    end

    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
    ok_nxt     = emit ? (reason == ssv_pkg::FAIL_NONE) : ok_r;
    reason_nxt = emit ? reason : reason_r;
    temp_nxt   = emit ? good_nxt : temp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 4'd0;
      crc_r    <= 8'd0;
      seen_r   <= 1'b0;
      lo_r     <= 8'd0;
      hi_r     <= 8'd0;
      first_r  <= 1'b1;
      good_r   <= 16'd0;
      pov_r    <= ssv_pkg::POWER_ON_RESET;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      seen_r   <= seen_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      first_r  <= first_nxt;
      good_r   <= good_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr_en) begin
        pov_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r     <= ok_nxt;
    reason_r <= reason_nxt;
    temp_r   <= temp_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_reading_ok  = ok_r;
  assign out_fail_reason = reason_r;
  assign out_temperature = temp_r;

endmodule

// ===== design/ssv_checker.sv =====
// port-level checker for the sensor scratchpad validator, bound to the top
// depends on ssv_pkg and sensor_scratchpad_validator_assert.svh
`include "sensor_scratchpad_validator_assert.svh"

module ssv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_reading_ok,
  input logic [2:0]         out_fail_reason,
  input logic signed [15:0] out_temperature
);

  // a stalled result holds
  `SSV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_fail_reason) && $stable(out_temperature),
    "result changed while stalled")

  // ok flag agrees with the reason code
  `SSV_ASSERT_NOW(a_ok_reason, out_valid,
    out_reading_ok == (out_fail_reason == ssv_pkg::FAIL_NONE),
    "reading_ok disagrees with fail_reason")

  // only defined reason codes
  `SSV_ASSERT_NOW(a_reason_range, out_valid,
    out_fail_reason <= ssv_pkg::FAIL_LEFTOVER,
    "undefined fail_reason")

  // input side never stalls while the output register is free
  `SSV_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready,
    "input stalled with free output register")

  // an absent transfer always gives a result next cycle
  `SSV_ASSERT_NEXT(a_absent_result,
    in_valid && in_ready && (in_opcode == ssv_pkg::OP_ABSENT),
    out_valid && (out_fail_reason == ssv_pkg::FAIL_ABSENT),
    "absent transfer gave no absent result")

endmodule

bind sensor_scratchpad_validator ssv_checker u_ssv_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for sensor_scratchpad_validator: random and directed scratchpad readouts
// with a scoreboard class that predicts each result; depends on ssv_pkg and the rtl

typedef struct {
  logic               reading_ok;
  logic [2:0]         fail_reason;
  logic signed [15:0] temperature;
} reading_t;

function automatic logic [7:0] crc8_absorb(logic [7:0] crc, logic [7:0] b);
  int i;
  for (i = 0; i < 8; i++) begin
    if (crc[0] ^ b[0]) begin
      crc = (crc >> 1) ^ ssv_pkg::CRC_POLY;
    end else begin
      crc = crc >> 1;
    end
    b = b >> 1;
  end
  return crc;
endfunction

class readout_scoreboard;
  logic [15:0] power_on_value;
  logic [3:0]  byte_position;
  logic [7:0]  running_crc;
  logic        seen_nonzero;
  logic [7:0]  low_byte;
  logic [7:0]  high_byte;
  logic        first_reading;
  logic [15:0] last_good_temp;
  reading_t    expected_readings[$];
  int          mismatches;

  function new();
    power_on_value = ssv_pkg::POWER_ON_RESET;
    first_reading  = 1'b1;
    last_good_temp = '0;
    mismatches     = 0;
    clear_readout();
  endfunction

  function void clear_readout();
    byte_position = '0;
    running_crc   = '0;
    seen_nonzero  = 1'b0;
    low_byte      = '0;
    high_byte     = '0;
  endfunction

  function void set_power_on(logic [15:0] value);
    power_on_value = value;
  endfunction

  function void push_reading(logic [2:0] reason);
    reading_t r;
    r.reading_ok  = (reason == ssv_pkg::FAIL_NONE);
    r.fail_reason = reason;
    r.temperature = last_good_temp;
    expected_readings.push_back(r);
  endfunction

  // one accepted input transfer
  function void note_transfer(logic opcode, logic [7:0] b);
    logic [15:0] value;
    logic [2:0]  reason;
    if (opcode == ssv_pkg::OP_ABSENT) begin
      clear_readout();
      push_reading(ssv_pkg::FAIL_ABSENT);
      return;
    end
    if (b != 8'd0) seen_nonzero = 1'b1;
    if (byte_position < ssv_pkg::CRC_BYTES) begin
      running_crc = crc8_absorb(running_crc, b);
      if (byte_position == 4'd0) low_byte = b;
      else if (byte_position == 4'd1) high_byte = b;
      byte_position = byte_position + 4'd1;
      return;
    end
    value = {high_byte, low_byte};
    if (!seen_nonzero) begin
      reason = ssv_pkg::FAIL_ZERO;
    end else if (running_crc != b) begin
      reason = ssv_pkg::FAIL_CRC;
    end else if (first_reading && value == power_on_value) begin
      first_reading = 1'b0;
      reason = ssv_pkg::FAIL_LEFTOVER;
    end else begin
      first_reading  = 1'b0;
      last_good_temp = value;
      reason = ssv_pkg::FAIL_NONE;
    end
    clear_readout();
    push_reading(reason);
  endfunction

  // one accepted result transfer
  function void check_reading(logic ok, logic [2:0] reason, logic signed [15:0] temp);
    reading_t e;
    if (expected_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: unexpected result ok=%0b reason=%0d temp=%0d", ok, reason, temp);
      return;
    end
    e = expected_readings.pop_front();
    if (ok !== e.reading_ok || reason !== e.fail_reason || temp !== e.temperature) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected ok=%0b reason=%0d temp=%0d, got ok=%0b reason=%0d temp=%0d",
                 e.reading_ok, e.fail_reason, e.temperature, ok, reason, temp);
    end
  endfunction
endclass

module tb_top;

  localparam int STALL_LIMIT = 2000;

  typedef enum {
    READOUT_GOOD,
    READOUT_BAD_CRC,
    READOUT_ZERO,
    READOUT_ABORTED,
    READOUT_NOISE
  } readout_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = ssv_pkg::OP_BYTE;
  logic [7:0]         in_data_byte = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_reading_ok;
  logic [2:0]         out_fail_reason;
  logic signed [15:0] out_temperature;
  logic               cfg_wr_en = 1'b0;
  logic signed [15:0] cfg_wr_data = '0;

  readout_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          sent_items = 0;
  logic [15:0] cur_power_on = ssv_pkg::POWER_ON_RESET;

  always #10 clk = ~clk;

  sensor_scratchpad_validator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reading_ok  (out_reading_ok),
    .out_fail_reason (out_fail_reason),
    .out_temperature (out_temperature),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_transfer(in_opcode, in_data_byte);
      if (out_valid && out_ready)
        sb.check_reading(out_reading_ok, out_fail_reason, out_temperature);
    end
  end

  // result receiver, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input logic opcode, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= opcode;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_power_on(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_power_on(value);
    cur_power_on = value;
  endtask

  task automatic send_readout(input readout_kind_t kind, input logic [15:0] temp);
    logic [7:0] frame [9];
    logic [7:0] crc;
    int         i;
    int         count;
    frame[0] = temp[7:0];
    frame[1] = temp[15:8];
    for (i = 2; i < 8; i++) frame[i] = 8'($urandom_range(255));
    if (kind == READOUT_ZERO || (kind == READOUT_BAD_CRC && $urandom_range(3) == 0)) begin
      for (i = 0; i < 8; i++) frame[i] = 8'd0;
    end
    crc = 8'd0;
    for (i = 0; i < 8; i++) crc = crc8_absorb(crc, frame[i]);
    frame[8] = (kind == READOUT_BAD_CRC) ? crc ^ 8'($urandom_range(255, 1)) : crc;
    if (kind == READOUT_ZERO) frame[8] = 8'd0;
    case (kind)
      READOUT_ABORTED: begin
        count = $urandom_range(8);
        for (i = 0; i < count; i++) send_item(ssv_pkg::OP_BYTE, frame[i]);
        send_item(ssv_pkg::OP_ABSENT, 8'($urandom_range(255)));
      end
      READOUT_NOISE: begin
        count = $urandom_range(12, 1);
        for (i = 0; i < count; i++) send_item(ssv_pkg::OP_BYTE, 8'($urandom_range(255)));
        send_item(ssv_pkg::OP_ABSENT, 8'($urandom_range(255)));
      end
      default: begin
        for (i = 0; i < 9; i++) send_item(ssv_pkg::OP_BYTE, frame[i]);
      end
    endcase
  endtask

  task automatic run_random(input int goal);
    int          pick;
    logic [15:0] temp;
    while (sent_items < goal) begin
      case ($urandom_range(7))
        0: temp = 16'h8000;
        1: temp = 16'h7FFF;
        2: temp = cur_power_on;
        default: temp = 16'($urandom_range(16'hFFFF));
      endcase
      pick = $urandom_range(99);
      if (pick < 60) send_readout(READOUT_GOOD, temp);
      else if (pick < 75) send_readout(READOUT_BAD_CRC, temp);
      else if (pick < 82) send_readout(READOUT_ZERO, temp);
      else if (pick < 92) send_readout(READOUT_ABORTED, temp);
      else send_readout(READOUT_NOISE, temp);
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone absent, aborted partial readout, all-zero readout,
    // then a first good readout equal to the reset power-on value
    send_item(ssv_pkg::OP_ABSENT, 8'hFF);
    send_item(ssv_pkg::OP_BYTE, 8'hFF);
    send_item(ssv_pkg::OP_BYTE, 8'h00);
    send_item(ssv_pkg::OP_BYTE, 8'hA5);
    send_item(ssv_pkg::OP_ABSENT, 8'h00);
    send_readout(READOUT_ZERO, 16'h0000);
    send_readout(READOUT_GOOD, ssv_pkg::POWER_ON_RESET);
    drain_readings();
    write_power_on(16'($urandom_range(16'hFFFF)));

    send_idle_pct = 20;
    recv_idle_pct = 48;
    run_random(350);
    drain_readings();
    write_power_on(16'h8000);

    send_idle_pct = 48;
    recv_idle_pct = 20;
    run_random(680);
    drain_readings();
    write_power_on(16'h7FFF);

    // no idling; receiver holds off so the input side backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 60;
    run_random(1000);
    drain_readings();

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ssv_pkg.sv
design/ssv_crc8_byte.sv
design/sensor_scratchpad_validator.sv
design/ssv_checker.sv
dv/tb_top.sv
